// File: design/oirpm_pkg.sv
// ----------------------------------------------------------------------------
// oirpm_pkg
// Shared types and constants for the off-idle rpm adder sequencer.
// ----------------------------------------------------------------------------
package oirpm_pkg;

  // field widths
  localparam int PHASE_W  = 3;
  localparam int RPM_IN_W = 15;
  localparam int MAX_W    = 14;
  localparam int CFG_W    = 16;
  localparam int ADDER_W  = 13;
  localparam int STATE_W  = 3;
  localparam int CFG_IDX_W = 2;

  // decay divider: full adder times remaining ticks over decay length
  localparam int DIV_DEN_W = CFG_W;
  localparam int DIV_NUM_W = ADDER_W + DIV_DEN_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ADDER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_DELTA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_TICKS  = 2'd3;

  // engine phase codes
  localparam logic [PHASE_W-1:0] EP_CRANKING = 3'd0;
  localparam logic [PHASE_W-1:0] EP_COASTING = 3'd3;
  localparam logic [PHASE_W-1:0] EP_RUNNING  = 3'd4;

  typedef enum logic [STATE_W-1:0] {
    AS_INACTIVE    = 3'd0,
    AS_ARMED       = 3'd1,
    AS_STABILIZING = 3'd2,
    AS_WAITING     = 3'd3,
    AS_DECAYING    = 3'd4
  } adder_state_t;

endpackage

// File: design/oirpm_div.sv
// ----------------------------------------------------------------------------
// oirpm_div
// Restoring divider, one quotient bit per cycle, for the decay ramp.
// ----------------------------------------------------------------------------
module oirpm_div
  import oirpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] dividend,
  input  logic [DIV_DEN_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   shifted;
  logic                 q_bit;
  logic [DIV_DEN_W-1:0] rem_next;

  always_comb begin
    shifted  = {rem, quotient[DIV_NUM_W-1]};
    q_bit    = (shifted >= {1'b0, den});
    // remainder after a subtract is below the divisor, so it fits
    rem_next = q_bit ? DIV_DEN_W'(shifted - {1'b0, den}) : DIV_DEN_W'(shifted);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= rem_next;
        quotient <= {quotient[DIV_NUM_W-2:0], q_bit};
        cnt      <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/off_idle_rpm_adder_fsm.sv
// path: input beat to result beat through the done state when no decay ramp value
//   is needed, through the multiply, start, wait and done states in the decaying
//   state, the wait set by the bit-serial divider that forms the ramp value
// input: a new input beat is taken only while the sequencer is idle, not while one
//   is in flight; taken while a result waits
// reset: sequencer inactive, tick counter and previous rpm zero, config registers zero
// ----------------------------------------------------------------------------
// off_idle_rpm_adder_fsm
// Off-idle rpm adder sequencer with an iterative divider for the decay.
// ----------------------------------------------------------------------------
module off_idle_rpm_adder_fsm
  import oirpm_pkg::*;
#(
  parameter int RPM_WIDTH  = 15,
  parameter int TICK_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PHASE_W-1:0]   engine_phase,
  input  logic [RPM_IN_W-1:0]  engine_rpm,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDER_W-1:0]   adder_rpm,
  output logic [STATE_W-1:0]   adder_state
);

  localparam int CMP_W = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;
  localparam int DLT_W = CFG_W + 1;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_MUL,
    SQ_START,
    SQ_WAIT,
    SQ_DONE
  } seq_t;

  seq_t                  sq;
  logic [MAX_W-1:0]      max_adder;
  logic [CFG_W-1:0]      stable_delta;
  logic [CFG_W-1:0]      wait_ticks;
  logic [CFG_W-1:0]      decay_ticks;
  logic [RPM_WIDTH-1:0]  previous_rpm;
  adder_state_t          adder_phase;
  logic [TICK_WIDTH-1:0] phase_ticks;
  logic [ADDER_W-1:0]    res_adder;
  logic [DIV_DEN_W-1:0]  remain;
  logic [DIV_NUM_W-1:0]  product;

  logic                  enabled;
  logic [ADDER_W-1:0]    full;
  logic [RPM_WIDTH-1:0]  rpm_in;
  logic [RPM_WIDTH-1:0]  delta;
  logic [TICK_WIDTH-1:0] ticks_inc;
  adder_state_t          phase_next;
  logic [TICK_WIDTH-1:0] ticks_next;
  logic [ADDER_W-1:0]    adder_next;
  logic                  div_next;
  logic [DIV_DEN_W-1:0]  remain_next;
  logic                  accept;
  logic                  div_done;
  logic [DIV_NUM_W-1:0]  quotient;

  assign in_ready = (sq == SQ_IDLE);
  assign accept   = in_valid && in_ready;
  assign enabled  = !max_adder[MAX_W-1] && (max_adder != '0);
  assign full     = max_adder[ADDER_W-1:0];
  assign rpm_in   = RPM_WIDTH'(engine_rpm);

  always_comb begin
    delta       = (rpm_in >= previous_rpm) ? rpm_in - previous_rpm : previous_rpm - rpm_in;
    ticks_inc   = (phase_ticks == {TICK_WIDTH{1'b1}}) ? phase_ticks
                                                      : phase_ticks + TICK_WIDTH'(1);
    phase_next  = adder_phase;
    ticks_next  = phase_ticks;
    adder_next  = '0;
    div_next    = 1'b0;
    remain_next = DIV_DEN_W'(CMP_W'(decay_ticks) - CMP_W'(ticks_inc));
    priority if (!enabled || engine_phase == EP_CRANKING) begin
      phase_next = AS_INACTIVE;
    end else if (engine_phase == EP_COASTING || engine_phase == EP_RUNNING) begin
      phase_next = AS_ARMED;
      adder_next = full;
    end else begin
      unique case (adder_phase)
        AS_ARMED: begin
          phase_next = AS_STABILIZING;
          adder_next = full;
        end
        AS_STABILIZING: begin
          if (DLT_W'(delta) < DLT_W'(stable_delta)) begin
            phase_next = AS_WAITING;
            ticks_next = '0;
          end
          adder_next = full;
        end
        AS_WAITING: begin
          ticks_next = ticks_inc;
          if (CMP_W'(ticks_inc) >= CMP_W'(wait_ticks)) begin
            phase_next = AS_DECAYING;
            ticks_next = '0;
          end
          adder_next = full;
        end
        AS_DECAYING: begin
          ticks_next = ticks_inc;
          if (decay_ticks == '0 || CMP_W'(ticks_inc) >= CMP_W'(decay_ticks)) begin
            phase_next = AS_INACTIVE;
          end else begin
            div_next = 1'b1;
          end
        end
        default: begin
          phase_next = AS_INACTIVE;
        end
      endcase
    end
  end

  oirpm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (sq == SQ_START),
    .dividend (product),
    .divisor  (decay_ticks),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sq           <= SQ_IDLE;
      max_adder    <= '0;
      stable_delta <= '0;
      wait_ticks   <= '0;
      decay_ticks  <= '0;
      previous_rpm <= '0;
      adder_phase  <= AS_INACTIVE;
      phase_ticks  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_ADDER:    max_adder    <= cfg_data[MAX_W-1:0];
          REG_STABLE_DELTA: stable_delta <= cfg_data;
          REG_WAIT_TICKS:   wait_ticks   <= cfg_data;
          REG_DECAY_TICKS:  decay_ticks  <= cfg_data;
          default: ;
        endcase
      end

      // a new beat in the done state takes over the handshake below
      if (out_valid && out_ready && sq != SQ_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (sq)
        SQ_IDLE: begin
          if (accept) begin
            previous_rpm <= rpm_in;
            adder_phase  <= phase_next;
            phase_ticks  <= ticks_next;
            res_adder    <= adder_next;
            remain       <= remain_next;
            sq           <= div_next ? SQ_MUL : SQ_DONE;
          end
        end
        SQ_MUL: begin
          product <= DIV_NUM_W'(full * remain);
          sq      <= SQ_START;
        end
        SQ_START: begin
          sq <= SQ_WAIT;
        end
        SQ_WAIT: begin
          if (div_done) begin
            // ramp value never exceeds the full adder
            res_adder <= quotient[ADDER_W-1:0];
            sq        <= SQ_DONE;
          end
        end
        SQ_DONE: begin
          // hold until the previous result beat has gone
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            adder_rpm   <= res_adder;
            adder_state <= STATE_W'(adder_phase);
            sq          <= SQ_IDLE;
          end
        end
        default: begin
          sq <= SQ_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/tb_off_idle_rpm_adder_fsm.sv
// ----------------------------------------------------------------------------
// tb_off_idle_rpm_adder_fsm
// Self-checking bench for the off-idle rpm adder sequencer. Control ticks go
// in through a valid/ready sender with random gaps, and a behavioral model
// works out the adder and state for each accepted tick. Each result beat is
// compared in order against that model. Directed tests cover the register
// extremes, every engine phase code and a long wait length.
// A long output stall is also tested. Random drive cycles follow under
// several register settings.
// ----------------------------------------------------------------------------
module tb_off_idle_rpm_adder_fsm;
  import oirpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 750;
  localparam int RANDOM_PHASES = 7;
  localparam int RPM_MAX       = 2**RPM_IN_W - 1;
  localparam int REPORT_LIMIT  = 10;
  localparam int LONG_WAIT     = 40;

  localparam logic [PHASE_W-1:0] PH_CRANK_TAPER   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_IDLING        = 3'd2;
  localparam logic [PHASE_W-1:0] PH_UNKNOWN_FIRST = 3'd5;
  localparam logic [PHASE_W-1:0] PH_UNKNOWN_LAST  = 3'd7;

  typedef struct packed {
    logic [ADDER_W-1:0] adder;
    adder_state_t       state;
  } tick_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PHASE_W-1:0]   engine_phase = '0;
  logic [RPM_IN_W-1:0]  engine_rpm = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDER_W-1:0]   adder_rpm;
  logic [STATE_W-1:0]   adder_state;

  // sequencer model: registers and state
  logic [MAX_W-1:0]     cfg_max;
  logic [CFG_W-1:0]     cfg_stable;
  logic [CFG_W-1:0]     cfg_wait;
  logic [CFG_W-1:0]     cfg_decay;
  logic [RPM_IN_W-1:0]  last_rpm;
  adder_state_t         seq_state;
  logic [15:0]          seq_ticks;

  tick_result_t         expected_adder_q[$];
  int                   mismatch_count = 0;
  int                   items_sent = 0;
  int                   cycle_count = 0;
  bit                   in_idle_en = 1'b1;
  bit                   out_idle_en = 1'b1;
  bit                   hold_req = 1'b0;

  off_idle_rpm_adder_fsm dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .engine_phase (engine_phase),
    .engine_rpm   (engine_rpm),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .adder_rpm    (adder_rpm),
    .adder_state  (adder_state)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic tick_result_t advance_sequencer(input logic [PHASE_W-1:0] code,
                                                     input logic [RPM_IN_W-1:0] rpm);
    tick_result_t       res;
    logic [RPM_IN_W-1:0] delta;
    logic [ADDER_W-1:0] full;
    logic               enabled;
    logic [31:0]        ramp;
    delta   = (rpm >= last_rpm) ? rpm - last_rpm : last_rpm - rpm;
    enabled = !cfg_max[MAX_W-1] && (cfg_max != '0);
    full    = cfg_max[ADDER_W-1:0];
    res.adder = '0;
    last_rpm = rpm;
    if (!enabled || code == EP_CRANKING) begin
      seq_state = AS_INACTIVE;
    end else if (code == EP_COASTING || code == EP_RUNNING) begin
      seq_state = AS_ARMED;
      res.adder = full;
    end else begin
      case (seq_state)
        AS_ARMED: begin
          seq_state = AS_STABILIZING;
          res.adder = full;
        end
        AS_STABILIZING: begin
          if (delta < cfg_stable) begin
            seq_state = AS_WAITING;
            seq_ticks = '0;
          end
          res.adder = full;
        end
        AS_WAITING: begin
          if (seq_ticks != '1) seq_ticks++;
          if (seq_ticks >= cfg_wait) begin
            seq_state = AS_DECAYING;
            seq_ticks = '0;
          end
          res.adder = full;
        end
        AS_DECAYING: begin
          if (seq_ticks != '1) seq_ticks++;
          if (cfg_decay == '0 || seq_ticks >= cfg_decay) begin
            seq_state = AS_INACTIVE;
          end else begin
            ramp = (32'(full) * 32'(cfg_decay - seq_ticks)) / 32'(cfg_decay);
            res.adder = ramp[ADDER_W-1:0];
          end
        end
        default: seq_state = AS_INACTIVE;
      endcase
    end
    res.state = seq_state;
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatch_count < REPORT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // predict on each input beat, check each result beat against the oldest
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_adder_q.push_back(advance_sequencer(engine_phase, engine_rpm));
      if (out_valid && out_ready) begin
        if (expected_adder_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result adder %0d state %0d",
                                  adder_rpm, adder_state));
        end else begin
          want = expected_adder_q.pop_front();
          if (adder_rpm !== want.adder || adder_state !== want.state)
            flag_mismatch($sformatf("expected adder %0d state %0d, got adder %0d state %0d",
                                    want.adder, want.state, adder_rpm, adder_state));
        end
      end
    end
  end

  // receiver: random stall bursts, or one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        out_ready = 1'b1;
      end else if (out_idle_en && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_tick(input logic [PHASE_W-1:0] code, input logic [RPM_IN_W-1:0] rpm);
    int gap;
    gap = (in_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    engine_phase = code;
    engine_rpm   = rpm;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_adder_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      REG_MAX_ADDER:    cfg_max    = value[MAX_W-1:0];
      REG_STABLE_DELTA: cfg_stable = value;
      REG_WAIT_TICKS:   cfg_wait   = value;
      REG_DECAY_TICKS:  cfg_decay  = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input int max_val, input int stable, input int hold, input int decay);
    write_reg(REG_MAX_ADDER, CFG_W'(max_val));
    write_reg(REG_STABLE_DELTA, CFG_W'(stable));
    write_reg(REG_WAIT_TICKS, CFG_W'(hold));
    write_reg(REG_DECAY_TICKS, CFG_W'(decay));
  endtask

  // registers all zero after reset, so the adder is off
  task automatic test_reset_state();
    send_tick(EP_RUNNING, 15'd0);
  endtask

  task automatic test_full_sequence();
    wait_results_drained();
    set_config(5000, 50, 2, 4);
    send_tick(EP_RUNNING, RPM_IN_W'(RPM_MAX));
    send_tick(PH_IDLING, 15'd1200);
    send_tick(PH_IDLING, 15'd1100);
    send_tick(PH_IDLING, 15'd1080);
    repeat (6) send_tick(PH_IDLING, 15'd1080);
  endtask

  task automatic test_engine_phases();
    wait_results_drained();
    set_config(3000, 10, 1, 3);
    send_tick(EP_COASTING, 15'd900);
    send_tick(PH_CRANK_TAPER, 15'd900);
    for (int c = PH_UNKNOWN_FIRST; c <= PH_UNKNOWN_LAST; c++)
      send_tick(PHASE_W'(c), 15'd900);
    send_tick(EP_CRANKING, 15'd150);
    send_tick(PH_IDLING, 15'd700);
  endtask

  task automatic test_register_extremes();
    // adder above the nominal range, and a threshold nothing can get under
    wait_results_drained();
    set_config(8191, 0, 0, 0);
    send_tick(EP_RUNNING, 15'd0);
    send_tick(PH_IDLING, 15'd0);
    send_tick(PH_IDLING, 15'd0);
    // smallest adder, longest decay, then a zero decay length
    wait_results_drained();
    write_reg(REG_MAX_ADDER, CFG_W'(1));
    write_reg(REG_STABLE_DELTA, 16'hFFFF);
    write_reg(REG_DECAY_TICKS, 16'hFFFF);
    send_tick(PH_IDLING, RPM_IN_W'(RPM_MAX));
    send_tick(PH_IDLING, RPM_IN_W'(RPM_MAX));
    send_tick(PH_IDLING, 15'd0);
    wait_results_drained();
    write_reg(REG_DECAY_TICKS, 16'h0000);
    send_tick(PH_IDLING, 15'd0);
    // most negative adder disables
    wait_results_drained();
    write_reg(REG_MAX_ADDER, 16'hE000);
    send_tick(EP_RUNNING, 15'd2000);
  endtask

  task automatic test_output_backpressure();
    wait_results_drained();
    set_config(3000, 100, 3, 5);
    in_idle_en = 1'b0;
    hold_req   = 1'b1;
    repeat (2) send_tick(EP_RUNNING, 15'd2500);
    repeat (18) send_tick(PH_IDLING, 15'd1000);
    wait_results_drained();
    in_idle_en = 1'b1;
  endtask

  // wait length well past the first few ticks, then a short decay
  task automatic test_long_wait();
    wait_results_drained();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    set_config(2000, 1, LONG_WAIT, 2);
    send_tick(EP_RUNNING, 15'd1000);
    repeat (2) send_tick(PH_IDLING, 15'd1000);
    repeat (LONG_WAIT + 2) send_tick(PH_IDLING, 15'd1000);
    wait_results_drained();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // off-idle burst, then a return to idle with settling speed and some noise
  task automatic drive_cycle();
    int                 speed;
    int                 r;
    logic [PHASE_W-1:0] code;
    repeat ($urandom_range(1, 4))
      send_tick($urandom_range(0, 1) ? EP_RUNNING : EP_COASTING,
                RPM_IN_W'($urandom_range(0, RPM_MAX)));
    speed = $urandom_range(500, 4000);
    repeat ($urandom_range(3, 60)) begin
      if ($urandom_range(0, 24) == 0) begin
        speed = $urandom_range(0, RPM_MAX);
      end else begin
        speed = speed + int'($urandom_range(0, 40)) - 20;
        if (speed < 0) speed = 0;
        if (speed > RPM_MAX) speed = RPM_MAX;
      end
      r = $urandom_range(0, 99);
      if (r < 78)      code = PH_IDLING;
      else if (r < 87) code = PH_CRANK_TAPER;
      else if (r < 93) code = PHASE_W'($urandom_range(PH_UNKNOWN_FIRST, PH_UNKNOWN_LAST));
      else if (r < 97) code = EP_CRANKING;
      else             code = $urandom_range(0, 1) ? EP_RUNNING : EP_COASTING;
      send_tick(code, RPM_IN_W'(speed));
    end
  endtask

  task automatic test_random_drive();
    int max_val;
    int stable;
    int hold;
    int decay;
    int goal;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_results_drained();
      case ($urandom_range(0, 7))
        0:       max_val = 0;
        1:       max_val = -int'($urandom_range(1, 5000));
        2:       max_val = 5000;
        3:       max_val = 8191;
        default: max_val = $urandom_range(1, 5000);
      endcase
      stable = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 120);
      hold   = $urandom_range(0, 12);
      decay  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 24);
      set_config(max_val, stable, hold, decay);
      // the closing stretch runs with no idling on either side
      in_idle_en  = (p < RANDOM_PHASES - 2);
      out_idle_en = (p < RANDOM_PHASES - 2);
      goal = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < goal) drive_cycle();
    end
  endtask

  initial begin
    cfg_max    = '0;
    cfg_stable = '0;
    cfg_wait   = '0;
    cfg_decay  = '0;
    last_rpm   = '0;
    seq_state  = AS_INACTIVE;
    seq_ticks  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_full_sequence();
    test_engine_phases();
    test_register_extremes();
    test_output_backpressure();
    test_long_wait();
    test_random_drive();
    wait_results_drained();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
